### hw/rtl/lrf_pkg.sv
// Shared constants, payload types and control types for the line raster frame buffer.
package lrf_pkg;

  localparam int FRAME_ROWS  = 64;
  localparam int FRAME_COLS  = 128;
  localparam int ROW_BYTES   = (FRAME_COLS + 7) / 8;
  localparam int STORE_BYTES = FRAME_ROWS * ROW_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int ROW_W       = $clog2(FRAME_ROWS + 1);
  localparam int COL_W       = $clog2(FRAME_COLS + 1);

  localparam int MODE_W  = 2;
  localparam int COORD_W = 8;
  localparam int IDX_W   = 10;
  localparam int BYTE_W  = 8;
  localparam int VROW_W  = 7;
  localparam int VCOL_W  = 8;
  localparam int ERR_W   = COORD_W + 4;

  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [IDX_W-1:0]   byte_index;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [VROW_W-1:0] dirty_top;
    logic [VROW_W-1:0] dirty_bottom;
    logic [VCOL_W-1:0] dirty_left;
    logic [VCOL_W-1:0] dirty_right;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rect_clear;
    logic sweep_start;
    logic sweep_we;
    logic rd_idx;
    logic pix_we;
    logic step;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic in_frame;
    logic at_end;
  } ctrl_status_t;

endpackage

### hw/rtl/lrf_datapath.sv
// Datapath of the line raster frame buffer: frame memory, line stepper and dirty rectangle.
module lrf_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrf_pkg::in_item_t    item_i,
  input  lrf_pkg::ctrl_cmd_t   cmd_i,
  output lrf_pkg::ctrl_status_t status_o,
  output lrf_pkg::out_item_t   result_o
);

  logic [lrf_pkg::BYTE_W-1:0] mem [lrf_pkg::STORE_BYTES];
  logic [lrf_pkg::BYTE_W-1:0] rdata_q;

  logic [lrf_pkg::MODE_W-1:0]  mode_q;
  logic [lrf_pkg::IDX_W-1:0]   idx_q;
  logic [lrf_pkg::COORD_W-1:0] x_q, y_q, x1_q, y1_q, dx_q, dy_q;
  logic                        sx_q, sy_q;
  logic signed [lrf_pkg::ERR_W-1:0] err_q;

  logic [lrf_pkg::ROW_W-1:0] top_q, bottom_q;
  logic [lrf_pkg::COL_W-1:0] left_q, right_q;
  logic [lrf_pkg::ADDR_W-1:0] cnt_q;
  lrf_pkg::out_item_t result_q;

  logic [lrf_pkg::COORD_W-1:0] dx_d, dy_d;
  logic signed [lrf_pkg::ERR_W:0] e2, dx_s, dy_s, err_n;
  logic step_x, step_y;
  logic [lrf_pkg::ADDR_W-1:0] pix_addr, raddr, waddr;
  logic [lrf_pkg::BYTE_W-1:0] mask, wdata;
  logic we, idx_ok;
  logic [lrf_pkg::ROW_W-1:0] y_row;
  logic [lrf_pkg::COL_W-1:0] x_col;

  always_comb begin
    dx_d = (item_i.x_end >= item_i.x_start) ? item_i.x_end - item_i.x_start
                                            : item_i.x_start - item_i.x_end;
    dy_d = (item_i.y_end >= item_i.y_start) ? item_i.y_end - item_i.y_start
                                            : item_i.y_start - item_i.y_end;
    e2     = {err_q, 1'b0};
    dx_s   = $signed({{(lrf_pkg::ERR_W + 1 - lrf_pkg::COORD_W){1'b0}}, dx_q});
    dy_s   = $signed({{(lrf_pkg::ERR_W + 1 - lrf_pkg::COORD_W){1'b0}}, dy_q});
    step_x = (e2 > -dy_s);
    step_y = (e2 < dx_s);
    err_n  = (lrf_pkg::ERR_W + 1)'(err_q) - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
    pix_addr = lrf_pkg::ADDR_W'(32'(y_q) * lrf_pkg::ROW_BYTES + 32'(x_q >> 3));
    mask     = 8'h80 >> x_q[2:0];
    y_row    = lrf_pkg::ROW_W'(y_q);
    x_col    = lrf_pkg::COL_W'(x_q);
    idx_ok   = (32'(idx_q) < lrf_pkg::STORE_BYTES);
    raddr    = cmd_i.rd_idx ? lrf_pkg::ADDR_W'(idx_q) : pix_addr;
    we       = cmd_i.sweep_we | cmd_i.pix_we;
    waddr    = cmd_i.sweep_we ? cnt_q : pix_addr;
    wdata    = cmd_i.sweep_we ? '0 : (rdata_q | mask);
  end

  assign status_o.sweep_last = (32'(cnt_q) == lrf_pkg::STORE_BYTES - 1);
  assign status_o.in_frame   = (32'(x_q) < lrf_pkg::FRAME_COLS) &&
                               (32'(y_q) < lrf_pkg::FRAME_ROWS);
  assign status_o.at_end     = (x_q == x1_q) && (y_q == y1_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= item_i.mode;
      idx_q  <= item_i.byte_index;
      x_q    <= item_i.x_start;
      y_q    <= item_i.y_start;
      x1_q   <= item_i.x_end;
      y1_q   <= item_i.y_end;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      sx_q   <= (item_i.x_start < item_i.x_end);
      sy_q   <= (item_i.y_start < item_i.y_end);
      err_q  <= lrf_pkg::ERR_W'($signed({1'b0, dx_d})) - lrf_pkg::ERR_W'($signed({1'b0, dy_d}));
    end else if (cmd_i.step) begin
      err_q <= lrf_pkg::ERR_W'(err_n);
      if (step_x) begin
        x_q <= sx_q ? x_q + 1'b1 : x_q - 1'b1;
      end
      if (step_y) begin
        y_q <= sy_q ? y_q + 1'b1 : y_q - 1'b1;
      end
    end
    if (cmd_i.res_load) begin
      result_q.read_byte    <= ((mode_q == lrf_pkg::MODE_READ) && idx_ok) ? rdata_q : '0;
      result_q.dirty_top    <= lrf_pkg::VROW_W'(top_q);
      result_q.dirty_bottom <= lrf_pkg::VROW_W'(bottom_q);
      result_q.dirty_left   <= lrf_pkg::VCOL_W'(left_q);
      result_q.dirty_right  <= lrf_pkg::VCOL_W'(right_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= lrf_pkg::ROW_W'(lrf_pkg::FRAME_ROWS);
      bottom_q <= '0;
      left_q   <= lrf_pkg::COL_W'(lrf_pkg::FRAME_COLS);
      right_q  <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.rect_clear) begin
        top_q    <= lrf_pkg::ROW_W'(lrf_pkg::FRAME_ROWS);
        bottom_q <= '0;
        left_q   <= lrf_pkg::COL_W'(lrf_pkg::FRAME_COLS);
        right_q  <= '0;
      end else if (cmd_i.pix_we) begin
        if (top_q > y_row) begin
          top_q <= y_row;
        end
        if (bottom_q <= y_row) begin
          bottom_q <= y_row + 1'b1;
        end
        if (left_q > x_col) begin
          left_q <= x_col;
        end
        if (right_q <= x_col) begin
          right_q <= x_col + 1'b1;
        end
      end
      if (cmd_i.sweep_start) begin
        cnt_q <= '0;
      end else if (cmd_i.sweep_we) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign result_o = result_q;

endmodule

### hw/rtl/lrf_ctrl.sv
// Controller state machine of the line raster frame buffer.
module lrf_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [lrf_pkg::MODE_W-1:0]  mode_i,
  input  lrf_pkg::ctrl_status_t       status_i,
  output lrf_pkg::ctrl_cmd_t          cmd_o,
  output logic                        busy,
  output logic                        done_o
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   report_q, report_d;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    done_d   = 1'b0;
    report_d = report_q;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_we = 1'b1;
        if (status_i.sweep_last) begin
          state_d = report_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (mode_i)
            lrf_pkg::MODE_DRAW: state_d = ST_PIX_RD;
            lrf_pkg::MODE_READ: state_d = ST_RD_WAIT;
            lrf_pkg::MODE_CLEAR: begin
              cmd_o.rect_clear  = 1'b1;
              cmd_o.sweep_start = 1'b1;
              report_d          = 1'b1;
              state_d           = ST_SWEEP;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_PIX_RD: begin
        if (status_i.in_frame) begin
          state_d = ST_PIX_WR;
        end else if (status_i.at_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_PIX_WR: begin
        cmd_o.pix_we = 1'b1;
        if (status_i.at_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_PIX_RD;
        end
      end
      ST_RD_WAIT: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.res_load = 1'b1;
        done_d         = 1'b1;
        report_d       = 1'b0;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SWEEP;
      done_q   <= 1'b0;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      report_q <= report_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

### hw/rtl/line_raster_framebuffer_unit.sv
// Top level of the line raster frame buffer: one-bit-per-pixel store with error-stepping lines.
// A read item loads the byte index, reads the byte and then strobes its result; mode 3 strobes without a read.
// A draw item visits each pixel in a read state and then a write state when it lies inside the frame,
// and only steps past pixels outside it; the registered read in each read-modify-write sets this.
// A clear item sweeps the 1024-byte store one byte a cycle and then strobes its result.
// After reset the same sweep runs with busy high and gives no result.
module line_raster_framebuffer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  lrf_pkg::in_item_t  item_i,
  output logic               busy,
  output logic               done_o,
  output lrf_pkg::out_item_t result_o
);

  lrf_pkg::ctrl_cmd_t    cmd;
  lrf_pkg::ctrl_status_t status;

  lrf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (item_i.mode),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  lrf_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

### tb/line_raster_framebuffer_unit_test.sv
// Self-checking testbench for the line raster frame buffer unit.
module line_raster_framebuffer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lrf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] LEFT_PIXEL  = 8'h80;
  localparam int                STALL_LIMIT = 6000;
  localparam int                RANDOM_ITEMS = 1300;
  localparam int                REPORT_LIMIT = 10;

  class framebuffer_scoreboard;
    logic [BYTE_W-1:0] frame_bytes [STORE_BYTES];
    int rect_top;
    int rect_bottom;
    int rect_left;
    int rect_right;
    out_item_t expected_q[$];
    int errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      rect_top    = FRAME_ROWS;
      rect_bottom = 0;
      rect_left   = FRAME_COLS;
      rect_right  = 0;
    endfunction

    function void set_pixel(int x, int y);
      int idx;
      if (x < 0 || y < 0 || x >= FRAME_COLS || y >= FRAME_ROWS) return;
      idx = y * ROW_BYTES + x / 8;
      frame_bytes[idx] = frame_bytes[idx] | (LEFT_PIXEL >> (x % 8));
      if (rect_top > y) rect_top = y;
      if (rect_bottom <= y) rect_bottom = y + 1;
      if (rect_left > x) rect_left = x;
      if (rect_right <= x) rect_right = x + 1;
    endfunction

    function void rasterize(int x0, int y0, int x1, int y1);
      int dx, dy, sx, sy, err, e2;
      dx  = (x1 >= x0) ? x1 - x0 : x0 - x1;
      dy  = (y1 >= y0) ? y1 - y0 : y0 - y1;
      sx  = (x0 < x1) ? 1 : -1;
      sy  = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      for (int n = 0; n < 1024; n++) begin
        set_pixel(x0, y0);
        if (x0 == x1 && y0 == y1) break;
        e2 = err + err;
        if (e2 > -dy) begin
          err -= dy;
          x0 += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y0 += sy;
        end
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t exp_item;
      logic [BYTE_W-1:0] rd;
      rd = '0;
      case (it.mode)
        MODE_DRAW: begin
          rasterize(int'(it.x_start), int'(it.y_start), int'(it.x_end), int'(it.y_end));
        end
        MODE_READ: begin
          if (int'(it.byte_index) < STORE_BYTES) rd = frame_bytes[it.byte_index];
        end
        MODE_CLEAR: begin
          wipe();
        end
        default: begin
        end
      endcase
      exp_item.read_byte    = rd;
      exp_item.dirty_top    = VROW_W'(rect_top);
      exp_item.dirty_bottom = VROW_W'(rect_bottom);
      exp_item.dirty_left   = VCOL_W'(rect_left);
      exp_item.dirty_right  = VCOL_W'(rect_right);
      expected_q.push_back(exp_item);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Result strobe with no transfer outstanding: %h", got);
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.read_byte !== exp_item.read_byte || got.dirty_top !== exp_item.dirty_top ||
          got.dirty_bottom !== exp_item.dirty_bottom ||
          got.dirty_left !== exp_item.dirty_left ||
          got.dirty_right !== exp_item.dirty_right) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Mismatch: expected byte %h rows %0d..%0d cols %0d..%0d, got byte %h rows %0d..%0d cols %0d..%0d",
                   exp_item.read_byte, exp_item.dirty_top, exp_item.dirty_bottom,
                   exp_item.dirty_left, exp_item.dirty_right,
                   got.read_byte, got.dirty_top, got.dirty_bottom,
                   got.dirty_left, got.dirty_right);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  in_item_t  item_i = '0;
  logic      busy;
  logic      done_o;
  out_item_t result_o;

  framebuffer_scoreboard sb = new();
  int  stall_cycles = 0;
  bit  idle_on = 1'b1;

  line_raster_framebuffer_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) sb.check_result(result_o);
      if (start && busy === 1'b0) sb.note_input(item_i);
    end
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [MODE_W-1:0] mode, int xs, int ys, int xe,
                                         int ye, int idx);
    logic [63:0] raw;
    in_item_t it;
    raw = {$urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    it.mode = mode;
    if (mode == MODE_DRAW) begin
      it.x_start = COORD_W'(xs);
      it.y_start = COORD_W'(ys);
      it.x_end   = COORD_W'(xe);
      it.y_end   = COORD_W'(ye);
    end else if (mode == MODE_READ) begin
      it.byte_index = IDX_W'(idx);
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 8) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  initial begin
    int sel, x0, y0, x1, y1, idx;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(make_item(MODE_READ, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_UNUSED, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_DRAW, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_DRAW, 127, 63, 127, 63, 0));
    send_item(make_item(MODE_READ, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_READ, 0, 0, 0, 0, STORE_BYTES - 1));
    send_item(make_item(MODE_DRAW, 0, 10, 127, 10, 0));
    send_item(make_item(MODE_DRAW, 5, 0, 5, 63, 0));
    send_item(make_item(MODE_DRAW, 127, 0, 0, 63, 0));
    send_item(make_item(MODE_READ, 0, 0, 0, 0, 10 * ROW_BYTES));
    send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_DRAW, 128, 0, 128, 0, 0));
    send_item(make_item(MODE_DRAW, 0, 64, 0, 64, 0));
    send_item(make_item(MODE_DRAW, 200, 100, 255, 255, 0));
    send_item(make_item(MODE_DRAW, 255, 255, 0, 0, 0));
    send_item(make_item(MODE_DRAW, 100, 40, 255, 200, 0));
    send_item(make_item(MODE_DRAW, 10, 63, 3, 0, 0));
    send_item(make_item(MODE_DRAW, 0, 255, 255, 0, 0));
    send_item(make_item(MODE_READ, 0, 0, 0, 0, 63 * ROW_BYTES + 15));
    send_item(make_item(MODE_READ, 0, 0, 0, 0, 1023));
    send_item(make_item(MODE_UNUSED, 255, 255, 255, 255, 1023));
    send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_READ, 0, 0, 0, 0, 0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 400 && n < 700);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          x0 = $urandom_range(0, FRAME_COLS - 1);
          y0 = $urandom_range(0, FRAME_ROWS - 1);
          x1 = $urandom_range(0, FRAME_COLS - 1);
          y1 = $urandom_range(0, FRAME_ROWS - 1);
        end else if (sel < 85) begin
          x0 = $urandom_range(0, 255);
          y0 = $urandom_range(0, 255);
          x1 = $urandom_range(0, 255);
          y1 = $urandom_range(0, 255);
        end else begin
          x0 = $urandom_range(0, FRAME_COLS - 1);
          y0 = $urandom_range(0, FRAME_ROWS - 1);
          x1 = x0 + $urandom_range(0, 16) - 8;
          y1 = y0 + $urandom_range(0, 16) - 8;
          if (x1 < 0) x1 = 0;
          if (y1 < 0) y1 = 0;
        end
        send_item(make_item(MODE_DRAW, x0, y0, x1, y1, 0));
      end else if (sel < 85) begin
        if (sb.rect_right > 0 && $urandom_range(0, 99) < 60) begin
          y0  = $urandom_range(sb.rect_top, sb.rect_bottom - 1);
          x0  = $urandom_range(sb.rect_left, sb.rect_right - 1);
          idx = y0 * ROW_BYTES + x0 / 8;
        end else begin
          idx = $urandom_range(0, 1023);
        end
        send_item(make_item(MODE_READ, 0, 0, 0, 0, idx));
      end else if (sel < 93) begin
        send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
      end else begin
        send_item(make_item(MODE_UNUSED, 0, 0, 0, 0, 0));
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### line_raster_framebuffer_unit.f
hw/rtl/lrf_pkg.sv
hw/rtl/lrf_datapath.sv
hw/rtl/lrf_ctrl.sv
hw/rtl/line_raster_framebuffer_unit.sv
tb/line_raster_framebuffer_unit_test.sv
